[design/c2d_pkg.sv]
`default_nettype none

package c2d_pkg;

	// Widths fixed by the stream fields.
	localparam int unsigned ELEM_W    = 16;
	localparam int unsigned SUM_W     = 35;
	localparam int unsigned OUT_IDX_W = 10;
	localparam int unsigned KROW_W    = 3 * ELEM_W;
	localparam int unsigned SIZE_W    = 11;
	localparam int unsigned CFG_IDX_W = 3;
	localparam int unsigned IN_TDATA_W  = 16;
	localparam int unsigned OUT_TDATA_W = 56;

	// Default geometry limits and queue depth.
	localparam int unsigned MAX_COLS_DEF = 1024;
	localparam int unsigned MAX_ROWS_DEF = 1024;
	localparam int unsigned QDEPTH       = 4;

	// Reset values of the configuration registers.
	localparam logic [KROW_W-1:0] KROW_RESET = 48'h0001_0001_0001;
	localparam logic [SIZE_W-1:0] SIZE_RESET = 11'd5;

	// Configuration register indexes.
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_KERNEL_TOP    = 3'd0,
		REG_KERNEL_MID    = 3'd1,
		REG_KERNEL_BOTTOM = 3'd2,
		REG_MATRIX_COLS   = 3'd3,
		REG_MATRIX_ROWS   = 3'd4
	} reg_idx_t;

	typedef logic [OUT_IDX_W-1:0] idx_t;

	// Position data that travels with each result.
	typedef struct packed {
		idx_t row;
		idx_t col;
		logic last;
	} meta_t;

	// One classified element: the new window column plus its position.
	typedef struct packed {
		logic [ELEM_W-1:0] top;
		logic [ELEM_W-1:0] mid;
		logic [ELEM_W-1:0] elem;
		logic              produce;
		meta_t             meta;
	} qent_t;

endpackage

`default_nettype wire

[design/conv2d_3x3_valid.sv]
// Streaming 3x3 correlation over the valid region of a raster matrix.
// Throughput: one element per clock cycle while the result side takes transfers.
// Path: after the transfer of its last element, a result reaches m_tdata through the line
// store read, the queue, the window register, and the products, row sums and final sum
// registers of the multiply-add.
// Reset: counters, queue and window cleared, kernel all ones, frame size 5 x 5;
// the line stores are not cleared, and entries are always written before use.
`default_nettype none

module conv2d_3x3_valid #(
	parameter int unsigned MAX_COLS = c2d_pkg::MAX_COLS_DEF,
	parameter int unsigned MAX_ROWS = c2d_pkg::MAX_ROWS_DEF
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	// Input stream; tdata: element[15:0].
	input  wire logic                                s_tvalid,
	output      logic                                s_tready,
	input  wire logic [c2d_pkg::IN_TDATA_W-1:0]      s_tdata,
	// Output stream; tdata: window_sum[34:0], out_row[44:35], out_col[54:45], zero[55].
	output      logic                                m_tvalid,
	input  wire logic                                m_tready,
	output      logic [c2d_pkg::OUT_TDATA_W-1:0]     m_tdata,
	output      logic                                m_tlast,
	// Configuration write channel.
	input  wire logic                                cfg_valid,
	output      logic                                cfg_ready,
	input  wire logic [c2d_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  wire logic [c2d_pkg::KROW_W-1:0]          cfg_data
);

	logic [2:0][c2d_pkg::KROW_W-1:0] kernel_q;
	logic [c2d_pkg::SIZE_W-1:0]      cols_q;
	logic [c2d_pkg::SIZE_W-1:0]      rows_q;
	logic                            cfg_wr;
	logic                            restart;
	logic                            push;
	c2d_pkg::qent_t                  push_data;
	logic                            pop;
	c2d_pkg::qent_t                  pop_data;
	logic                            q_not_empty;
	logic [$clog2(c2d_pkg::QDEPTH+1)-1:0] q_count;
	logic signed [c2d_pkg::SUM_W-1:0] out_sum;
	c2d_pkg::meta_t                  out_meta;

	assign cfg_ready = 1'b1;
	assign cfg_wr    = cfg_valid && cfg_ready;

	// Register write decode; a size write restarts the frame.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kernel_q[0] <= c2d_pkg::KROW_RESET;
			kernel_q[1] <= c2d_pkg::KROW_RESET;
			kernel_q[2] <= c2d_pkg::KROW_RESET;
			cols_q      <= c2d_pkg::SIZE_RESET;
			rows_q      <= c2d_pkg::SIZE_RESET;
		end else if (cfg_wr) begin
			unique case (cfg_index)
				c2d_pkg::REG_KERNEL_TOP:    kernel_q[0] <= cfg_data;
				c2d_pkg::REG_KERNEL_MID:    kernel_q[1] <= cfg_data;
				c2d_pkg::REG_KERNEL_BOTTOM: kernel_q[2] <= cfg_data;
				c2d_pkg::REG_MATRIX_COLS:   cols_q <= cfg_data[c2d_pkg::SIZE_W-1:0];
				c2d_pkg::REG_MATRIX_ROWS:   rows_q <= cfg_data[c2d_pkg::SIZE_W-1:0];
				default: ;
			endcase
		end
	end

	assign restart = cfg_wr && ((cfg_index == c2d_pkg::REG_MATRIX_COLS) ||
		(cfg_index == c2d_pkg::REG_MATRIX_ROWS));

	// Front: position tracking, line stores, classification.
	c2d_front #(
		.MAX_COLS(MAX_COLS),
		.MAX_ROWS(MAX_ROWS)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (s_tvalid),
		.in_ready    (s_tready),
		.in_elem     (s_tdata[c2d_pkg::ELEM_W-1:0]),
		.matrix_cols (cols_q),
		.matrix_rows (rows_q),
		.restart     (restart),
		.q_count     (q_count),
		.push        (push),
		.push_data   (push_data)
	);

	// Queue between front and back.
	c2d_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.pop       (pop),
		.pop_data  (pop_data),
		.not_empty (q_not_empty),
		.count     (q_count)
	);

	// Back: window and multiply-add pipeline.
	c2d_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.kernel      (kernel_q),
		.q_not_empty (q_not_empty),
		.q_data      (pop_data),
		.pop         (pop),
		.out_valid   (m_tvalid),
		.out_ready   (m_tready),
		.out_sum     (out_sum),
		.out_meta    (out_meta)
	);

	assign m_tdata = {1'b0, out_meta.col, out_meta.row, out_sum};
	assign m_tlast = out_meta.last;

endmodule

`default_nettype wire

[design/c2d_ram.sv]
`default_nettype none

module c2d_ram #(
	parameter int unsigned WIDTH = 16,
	parameter int unsigned DEPTH = 1024
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output      logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// Single write port, registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

[design/c2d_front.sv]
`default_nettype none

module c2d_front #(
	parameter int unsigned MAX_COLS = c2d_pkg::MAX_COLS_DEF,
	parameter int unsigned MAX_ROWS = c2d_pkg::MAX_ROWS_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          in_valid,
	output      logic                          in_ready,
	input  wire logic [c2d_pkg::ELEM_W-1:0]    in_elem,
	input  wire logic [c2d_pkg::SIZE_W-1:0]    matrix_cols,
	input  wire logic [c2d_pkg::SIZE_W-1:0]    matrix_rows,
	input  wire logic                          restart,
	input  wire logic [$clog2(c2d_pkg::QDEPTH+1)-1:0] q_count,
	output      logic                          push,
	output      c2d_pkg::qent_t                push_data
);

	localparam int unsigned CW = $clog2(MAX_COLS);
	localparam int unsigned RW = $clog2(MAX_ROWS);

	logic [CW-1:0] col_q;
	logic [RW-1:0] row_q;
	logic [CW-1:0] cols_m1;
	logic [RW-1:0] rows_m1;
	logic          accept;
	logic          valid_s1;
	logic [CW-1:0] col_s1;
	logic [c2d_pkg::ELEM_W-1:0] elem_s1;
	logic          produce_s1;
	c2d_pkg::meta_t meta_s1;
	logic [c2d_pkg::ELEM_W-1:0] rd_a;
	logic [c2d_pkg::ELEM_W-1:0] rd_b;

	// Effective frame size, clamped to 3 up to the configured maximum.
	always_comb begin
		if (32'(matrix_cols) < 32'd3) begin
			cols_m1 = CW'(2);
		end else if (32'(matrix_cols) > MAX_COLS) begin
			cols_m1 = CW'(MAX_COLS - 1);
		end else begin
			cols_m1 = CW'(32'(matrix_cols) - 32'd1);
		end
		if (32'(matrix_rows) < 32'd3) begin
			rows_m1 = RW'(2);
		end else if (32'(matrix_rows) > MAX_ROWS) begin
			rows_m1 = RW'(MAX_ROWS - 1);
		end else begin
			rows_m1 = RW'(32'(matrix_rows) - 32'd1);
		end
	end

	// Take an element only when the queue has room for it and the one in flight.
	assign in_ready = (32'(q_count) + 32'(valid_s1)) < c2d_pkg::QDEPTH;
	assign accept   = in_valid && in_ready;

	// Raster position counters.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (restart) begin
			col_q <= '0;
			row_q <= '0;
		end else if (accept) begin
			if (col_q == cols_m1) begin
				col_q <= '0;
				row_q <= (row_q == rows_m1) ? '0 : row_q + RW'(1);
			end else begin
				col_q <= col_q + CW'(1);
			end
		end
	end

	// Classification stage, aligned with the line store read.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			col_s1       <= col_q;
			elem_s1      <= in_elem;
			produce_s1   <= (32'(row_q) >= 32'd2) && (32'(col_q) >= 32'd2);
			meta_s1.row  <= c2d_pkg::idx_t'(32'(row_q) - 32'd2);
			meta_s1.col  <= c2d_pkg::idx_t'(32'(col_q) - 32'd2);
			meta_s1.last <= (row_q == rows_m1) && (col_q == cols_m1);
		end
	end

	// Line store a holds the previous row, line store b the row before it.
	c2d_ram #(
		.WIDTH(c2d_pkg::ELEM_W),
		.DEPTH(MAX_COLS)
	) u_line_a (
		.clk   (clk),
		.we    (valid_s1),
		.waddr (col_s1),
		.wdata (elem_s1),
		.raddr (col_q),
		.rdata (rd_a)
	);

	c2d_ram #(
		.WIDTH(c2d_pkg::ELEM_W),
		.DEPTH(MAX_COLS)
	) u_line_b (
		.clk   (clk),
		.we    (valid_s1),
		.waddr (col_s1),
		.wdata (rd_a),
		.raddr (col_q),
		.rdata (rd_b)
	);

	// Hand the new window column to the queue.
	assign push              = valid_s1;
	assign push_data.top     = rd_b;
	assign push_data.mid     = rd_a;
	assign push_data.elem    = elem_s1;
	assign push_data.produce = produce_s1;
	assign push_data.meta    = meta_s1;

endmodule

`default_nettype wire

[design/c2d_queue.sv]
`default_nettype none

module c2d_queue (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire logic                                 push,
	input  wire c2d_pkg::qent_t                       push_data,
	input  wire logic                                 pop,
	output      c2d_pkg::qent_t                       pop_data,
	output      logic                                 not_empty,
	output      logic [$clog2(c2d_pkg::QDEPTH+1)-1:0] count
);

	localparam int unsigned PW = $clog2(c2d_pkg::QDEPTH);
	localparam int unsigned NW = $clog2(c2d_pkg::QDEPTH + 1);

	c2d_pkg::qent_t mem_q [c2d_pkg::QDEPTH];
	logic [PW-1:0]  wr_ptr_q;
	logic [PW-1:0]  rd_ptr_q;
	logic [NW-1:0]  count_q;

	// Pointer and occupancy bookkeeping; the producer never pushes when full.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (32'(wr_ptr_q) == c2d_pkg::QDEPTH - 1) ? '0 : wr_ptr_q + PW'(1);
			end
			if (pop) begin
				rd_ptr_q <= (32'(rd_ptr_q) == c2d_pkg::QDEPTH - 1) ? '0 : rd_ptr_q + PW'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + NW'(1);
			end else if (pop && !push) begin
				count_q <= count_q - NW'(1);
			end
		end
	end

	// Entry storage.
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	assign pop_data  = mem_q[rd_ptr_q];
	assign not_empty = (count_q != '0);
	assign count     = count_q;

endmodule

`default_nettype wire

[design/c2d_back.sv]
`default_nettype none

module c2d_back (
	input  wire logic                                   clk,
	input  wire logic                                   arst_n,
	input  wire logic [2:0][c2d_pkg::KROW_W-1:0]        kernel,
	input  wire logic                                   q_not_empty,
	input  wire c2d_pkg::qent_t                         q_data,
	output      logic                                   pop,
	output      logic                                   out_valid,
	input  wire logic                                   out_ready,
	output      logic signed [c2d_pkg::SUM_W-1:0]       out_sum,
	output      c2d_pkg::meta_t                         out_meta
);

	logic signed [c2d_pkg::ELEM_W-1:0] window_q [3][3];
	logic signed [31:0]                prod_s2 [3][3];
	logic signed [33:0]                rowsum_s3 [3];
	logic signed [c2d_pkg::SUM_W-1:0]  sum_s4;
	logic           valid_s1;
	logic           valid_s2;
	logic           valid_s3;
	logic           valid_s4;
	c2d_pkg::meta_t meta_s1;
	c2d_pkg::meta_t meta_s2;
	c2d_pkg::meta_t meta_s3;
	c2d_pkg::meta_t meta_s4;
	logic           adv;

	// The whole pipeline moves when the output register is free or being emptied.
	assign adv = !valid_s4 || out_ready;
	assign pop = adv && q_not_empty;

	// Window shift: every element moves the window one column to the right.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 3; i++) begin
				for (int j = 0; j < 3; j++) begin
					window_q[i][j] <= '0;
				end
			end
		end else if (pop) begin
			for (int i = 0; i < 3; i++) begin
				window_q[i][0] <= window_q[i][1];
				window_q[i][1] <= window_q[i][2];
			end
			window_q[0][2] <= q_data.top;
			window_q[1][2] <= q_data.mid;
			window_q[2][2] <= q_data.elem;
		end
	end

	// Result valid flags through the arithmetic stages.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else if (adv) begin
			valid_s1 <= pop && q_data.produce;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
		end
	end

	// Nine products, then three row sums, then the final sum.
	always_ff @(posedge clk) begin
		if (adv) begin
			meta_s1 <= q_data.meta;
			meta_s2 <= meta_s1;
			meta_s3 <= meta_s2;
			meta_s4 <= meta_s3;
			for (int i = 0; i < 3; i++) begin
				for (int j = 0; j < 3; j++) begin
					prod_s2[i][j] <= window_q[i][j] *
						$signed(kernel[i][j*c2d_pkg::ELEM_W +: c2d_pkg::ELEM_W]);
				end
			end
			for (int i = 0; i < 3; i++) begin
				rowsum_s3[i] <= 34'(prod_s2[i][0]) + 34'(prod_s2[i][1]) +
					34'(prod_s2[i][2]);
			end
			sum_s4 <= 35'(rowsum_s3[0]) + 35'(rowsum_s3[1]) + 35'(rowsum_s3[2]);
		end
	end

	assign out_valid = valid_s4;
	assign out_sum   = sum_s4;
	assign out_meta  = meta_s4;

endmodule

`default_nettype wire
